### hw/rtl/pfr_pkg.sv
// ----------------------------------------------------------------------------
// pfr_pkg
// Shared widths, payload types and controller/datapath signal groups for the
// potential field repulsion block.
// ----------------------------------------------------------------------------
package pfr_pkg;

  localparam int GRID_H_DEF     = 64;
  localparam int GRID_W_DEF     = 128;
  localparam int MAX_RADIUS_DEF = 16;

  // field widths
  localparam int XW    = 15;
  localparam int YW    = 14;
  localparam int ROWW  = 6;
  localparam int COLW  = 7;
  localparam int PW    = 13;
  localparam int GW    = 32;
  localparam int AHW   = 7;
  localparam int AWW   = 8;
  localparam int SUMW  = 32;
  localparam int CFGIW = 2;

  // internal widths
  localparam int IW    = 11;           // row/col counters, covers 1024 and window bounds
  localparam int ABW   = 16;           // |dx|, |dy|
  localparam int RADW  = 34;           // dx^2 + dy^2
  localparam int ROOTW = 17;
  localparam int FRAC  = 24;
  localparam int NUMW  = GW + PW;      // eta * (rho - d)
  localparam int DENW  = 4 * PW;       // d^3 * rho
  localparam int QW    = NUMW + FRAC;  // divider width
  localparam int FW    = 41;           // term magnitude, up to the 2^40 cap
  localparam int PRODW = FW + ABW;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  localparam logic [CFGIW-1:0] REG_RADIUS = 2'd0;
  localparam logic [CFGIW-1:0] REG_GAIN   = 2'd1;
  localparam logic [CFGIW-1:0] REG_AREA_H = 2'd2;
  localparam logic [CFGIW-1:0] REG_AREA_W = 2'd3;

  typedef struct packed {
    logic            req_type;
    logic [ROWW-1:0] cell_row;
    logic [COLW-1:0] cell_col;
    logic            cell_blocked;
    logic [XW-1:0]   pos_x_q8;
    logic [YW-1:0]   pos_y_q8;
  } req_t;

  typedef struct packed {
    logic signed [SUMW-1:0] force_x;
    logic signed [SUMW-1:0] force_y;
    logic                   saturated;
  } res_t;

  typedef struct packed {
    logic [PW-1:0]  radius_q8;
    logic [GW-1:0]  gain_q16;
    logic [AHW-1:0] area_height;
    logic [AWW-1:0] area_width;
  } cfg_t;

  typedef struct packed {
    logic clr_wr;
    logic cell_wr;
    logic q_load;
    logic geom;
    logic sq_start;
    logic dist_load;
    logic m1;
    logic m2;
    logic m3;
    logic div_term;
    logic div_comp;
    logic f_cap;
    logic prod_x;
    logic prod_y;
    logic tx_cap;
    logic ty_cap;
    logic acc_cell;
    logic wall_init;
    logic wall_sel;
    logic acc_wall;
    logic wall_next;
    logic col_next;
    logic row_next;
    logic res_load;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic win_empty;
    logic occ;
    logic sq_done;
    logic d_ok;
    logic div_done;
    logic last_col;
    logic last_row;
    logic wall_last;
    logic out_busy;
  } sts_t;

endpackage

### hw/rtl/pfr_ifs.sv
// ----------------------------------------------------------------------------
// pfr_ifs
// Request, result and configuration channels (valid/ready).
// ----------------------------------------------------------------------------
interface pfr_req_if;
  import pfr_pkg::*;
  logic            valid;
  logic            ready;
  logic            req_type;
  logic [ROWW-1:0] cell_row;
  logic [COLW-1:0] cell_col;
  logic            cell_blocked;
  logic [XW-1:0]   pos_x_q8;
  logic [YW-1:0]   pos_y_q8;
  modport source (output valid, req_type, cell_row, cell_col, cell_blocked,
                  pos_x_q8, pos_y_q8, input ready);
  modport sink (input valid, req_type, cell_row, cell_col, cell_blocked,
                pos_x_q8, pos_y_q8, output ready);
endinterface

interface pfr_res_if;
  import pfr_pkg::*;
  logic                   valid;
  logic                   ready;
  logic signed [SUMW-1:0] force_x;
  logic signed [SUMW-1:0] force_y;
  logic                   saturated;
  modport source (output valid, force_x, force_y, saturated, input ready);
  modport sink (input valid, force_x, force_y, saturated, output ready);
endinterface

interface pfr_cfg_if;
  import pfr_pkg::*;
  logic             valid;
  logic             ready;
  logic [CFGIW-1:0] index;
  logic [GW-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### hw/rtl/pfr_ram.sv
// ----------------------------------------------------------------------------
// pfr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pfr_ram #(
  parameter int W     = 1,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/pfr_sqrt.sv
// ----------------------------------------------------------------------------
// pfr_sqrt
// Iterative integer square root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module pfr_sqrt (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [pfr_pkg::RADW-1:0]  rad,
  output logic                      done,
  output logic [pfr_pkg::ROOTW-1:0] root
);
  import pfr_pkg::*;

  localparam int CW = $clog2(ROOTW);

  logic [RADW-1:0]  val;
  logic [ROOTW+1:0] rem;
  logic [CW-1:0]    cnt;
  logic             run;
  logic [ROOTW+3:0] rem_sh;
  logic [ROOTW+3:0] trial;
  logic             ge;

  always_comb begin
    rem_sh = {rem, val[RADW-1 -: 2]};
    trial  = {2'b00, root, 2'b01};
    ge     = rem_sh >= trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(ROOTW - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      val  <= rad;
      rem  <= '0;
      root <= '0;
    end else if (run) begin
      val  <= {val[RADW-3:0], 2'b00};
      rem  <= ge ? (ROOTW+2)'(rem_sh - trial) : rem_sh[ROOTW+1:0];
      root <= {root[ROOTW-2:0], ge};
    end
  end

endmodule

### hw/rtl/pfr_div.sv
// ----------------------------------------------------------------------------
// pfr_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pfr_div #(
  parameter int NW = 8,
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo
);

  localparam int CW = $clog2(NW);

  logic [DW-1:0] dv;
  logic [DW-1:0] rem;
  logic [CW-1:0] cnt;
  logic          run;
  logic [DW:0]   rem_sh;
  logic          ge;

  always_comb begin
    rem_sh = {rem, quo[NW-1]};
    ge     = rem_sh >= {1'b0, dv};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(NW - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // dividend shifts out the top while quotient bits enter at the bottom
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= num;
      dv  <= den;
      rem <= '0;
    end else if (run) begin
      rem <= ge ? DW'(rem_sh - {1'b0, dv}) : rem_sh[DW-1:0];
      quo <= {quo[NW-2:0], ge};
    end
  end

endmodule

### hw/rtl/pfr_dp.sv
// ----------------------------------------------------------------------------
// pfr_dp
// Datapath: occupancy grid, scan window, distance, term magnitude, force
// components, saturating sums and the result register.
// ----------------------------------------------------------------------------
module pfr_dp #(
  parameter int GRID_H     = pfr_pkg::GRID_H_DEF,
  parameter int GRID_W     = pfr_pkg::GRID_W_DEF,
  parameter int MAX_RADIUS = pfr_pkg::MAX_RADIUS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  pfr_pkg::cmd_t cmd,
  output pfr_pkg::sts_t sts,
  input  pfr_pkg::cfg_t cfg,
  input  pfr_pkg::req_t req,
  output logic          res_valid,
  input  logic          res_ready,
  output pfr_pkg::res_t res
);
  import pfr_pkg::*;

  localparam int DEPTH = GRID_H * GRID_W;
  localparam int AW    = $clog2(DEPTH);
  localparam int LW    = AW + IW + 1;
  localparam int PLIM  = (MAX_RADIUS * 256 > (1 << PW) - 1) ? (1 << PW) - 1
                                                            : MAX_RADIUS * 256;
  localparam logic [PW-1:0] P_LIM = PLIM[PW-1:0];
  localparam int SW = 19;

  localparam logic [1:0] WALL_LEFT  = 2'd0;
  localparam logic [1:0] WALL_RIGHT = 2'd1;
  localparam logic [1:0] WALL_UP    = 2'd2;
  localparam logic [1:0] WALL_BOT   = 2'd3;

  localparam logic signed [SW-1:0] OFF_08   = 19'sd205;
  localparam logic signed [SW-1:0] OFF_18   = 19'sd461;
  localparam logic signed [SW-1:0] ONE_CELL = 19'sd256;

  function automatic logic [SUMW:0] sat_add(input logic signed [SUMW-1:0] a,
                                            input logic [PRODW-1:0] m,
                                            input logic neg);
    logic signed [PRODW+1:0] t;
    logic signed [PRODW+1:0] s;
    logic signed [PRODW+1:0] smax;
    logic signed [PRODW+1:0] smin;
    logic [SUMW:0]           r;
    smax = $signed((PRODW+2)'(32'h7fff_ffff));
    smin = -smax - $signed((PRODW+2)'(1));
    t    = $signed({2'b00, m});
    if (neg) t = -t;
    s = t + (PRODW+2)'(a);
    if (s > smax)      r = {1'b1, 32'h7fff_ffff};
    else if (s < smin) r = {1'b1, 32'h8000_0000};
    else               r = {1'b0, s[SUMW-1:0]};
    return r;
  endfunction

  // query registers
  logic [XW-1:0]          qx;
  logic [YW-1:0]          qy;
  logic [PW-1:0]          p;
  logic [IW-1:0]          r, c, c0, c1, r1;
  logic                   win_empty;
  logic [AW-1:0]          clr_cnt;
  logic [ABW-1:0]         adx, ady;
  logic                   sx, sy;
  logic [PW-1:0]          d;
  logic                   d_ok;
  logic [NUMW-1:0]        num;
  logic [2*PW-1:0]        dd;
  logic [3*PW-1:0]        d3;
  logic [DENW-1:0]        den;
  logic [FW-1:0]          f;
  logic [PRODW-1:0]       prod, tx, ty;
  logic [1:0]             widx;
  logic                   wneg;
  logic signed [SUMW-1:0] fx, fy;
  logic                   sat;

  // combinational
  logic [PW-1:0]          p_w;
  logic signed [XW+1:0]   xm;
  logic [XW:0]            xp;
  logic signed [YW+1:0]   ym;
  logic [YW:0]            yp;
  logic [IW-1:0]          c0_w, c1_w, r0_w, r1_w;
  logic [LW-1:0]          rd_lin, wr_lin;
  logic                   wr_ok;
  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic                   ram_wdata;
  logic                   occ;
  logic signed [IW+9:0]   dxs, dys;
  logic [RADW-1:0]        rad;
  logic                   sq_done;
  logic [ROOTW-1:0]       root;
  logic signed [ROOTW:0]  dr, dfl;
  logic signed [SW-1:0]   xs, ys, ws, hs, ps, wd, wfl;
  logic                   wcond, wneg_w;
  logic                   div_start, div_done;
  logic [QW-1:0]          div_num, quo;
  logic [DENW-1:0]        div_den;
  logic                   f_over;
  logic [SUMW:0]          add_x, add_y, add_w;

  always_comb begin
    if (cfg.radius_q8 == '0)       p_w = PW'(1);
    else if (cfg.radius_q8 > P_LIM) p_w = P_LIM;
    else                            p_w = cfg.radius_q8;

    xm   = $signed({2'b00, req.pos_x_q8}) - $signed({4'b0000, p_w});
    xp   = {1'b0, req.pos_x_q8} + {3'b000, p_w};
    ym   = $signed({2'b00, req.pos_y_q8}) - $signed({3'b000, p_w});
    yp   = {1'b0, req.pos_y_q8} + {2'b00, p_w};
    c0_w = xm[XW+1] ? '0 : IW'(xm[XW:8]);
    r0_w = ym[YW+1] ? '0 : IW'(ym[YW:8]);
    c1_w = (IW'(xp[XW:8]) > IW'(GRID_W - 1)) ? IW'(GRID_W - 1) : IW'(xp[XW:8]);
    r1_w = (IW'(yp[YW:8]) > IW'(GRID_H - 1)) ? IW'(GRID_H - 1) : IW'(yp[YW:8]);
  end

  // grid addressing
  always_comb begin
    rd_lin = LW'(r) * LW'(GRID_W) + LW'(c);
    wr_lin = LW'(req.cell_row) * LW'(GRID_W) + LW'(req.cell_col);
    wr_ok  = (IW'(req.cell_row) < IW'(GRID_H)) && (IW'(req.cell_col) < IW'(GRID_W));
    if (cmd.clr_wr) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt;
      ram_wdata = 1'b0;
    end else begin
      ram_we    = cmd.cell_wr && wr_ok;
      ram_waddr = wr_lin[AW-1:0];
      ram_wdata = req.cell_blocked;
    end
  end

  pfr_ram #(.W(1), .DEPTH(DEPTH)) u_grid (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_lin[AW-1:0]),
    .rdata (occ)
  );

  // offsets from the cell center
  always_comb begin
    dxs = $signed({6'b0, qx}) - $signed({1'b0, c, 8'h80});
    dys = $signed({7'b0, qy}) - $signed({1'b0, r, 8'h80});
    rad = RADW'(adx * adx) + RADW'(ady * ady);
  end

  pfr_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.sq_start),
    .rad   (rad),
    .done  (sq_done),
    .root  (root)
  );

  always_comb begin
    dr  = $signed({1'b0, root}) - $signed((ROOTW+1)'(128));
    dfl = (dr < $signed((ROOTW+1)'(1))) ? $signed((ROOTW+1)'(1)) : dr;
  end

  // wall distance, signed
  always_comb begin
    xs = $signed(SW'(qx));
    ys = $signed(SW'(qy));
    ws = $signed(SW'({cfg.area_width, 8'h00}));
    hs = $signed(SW'({cfg.area_height, 8'h00}));
    ps = $signed(SW'(p));
    case (widx)
      WALL_LEFT: begin
        wcond  = xs < ps;
        wd     = xs - OFF_08;
        wneg_w = 1'b0;
      end
      WALL_RIGHT: begin
        wcond  = (ws - xs - ONE_CELL) < ps;
        wd     = ws - xs - OFF_18;
        wneg_w = 1'b1;
      end
      WALL_UP: begin
        wcond  = ys < ps;
        wd     = ys - OFF_08;
        wneg_w = 1'b0;
      end
      default: begin
        wcond  = (hs - ys - ONE_CELL) < ps;
        wd     = hs - ys - ONE_CELL;
        wneg_w = 1'b1;
      end
    endcase
    wfl = (wd < $signed(SW'(1))) ? $signed(SW'(1)) : wd;
  end

  // shared divider: term magnitude or force component
  always_comb begin
    div_start = cmd.div_term || cmd.div_comp;
    if (cmd.div_term) begin
      div_num = {num, {FRAC{1'b0}}};
      div_den = den;
    end else begin
      div_num = QW'(prod);
      div_den = DENW'(d);
    end
  end

  pfr_div #(.NW(QW), .DW(DENW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (quo)
  );

  always_comb begin
    f_over = (|quo[QW-1:FW]) || (quo[FW-1] && (|quo[FW-2:0]));
    add_x  = sat_add(fx, tx, sx);
    add_y  = sat_add(fy, ty, sy);
    add_w  = sat_add((widx == WALL_LEFT || widx == WALL_RIGHT) ? fx : fy,
                     PRODW'(f), wneg);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt   <= '0;
      d_ok      <= 1'b0;
      res_valid <= 1'b0;
      win_empty <= 1'b0;
    end else begin
      if (cmd.clr_wr) clr_cnt <= clr_cnt + 1'b1;
      if (cmd.q_load) win_empty <= (r0_w > r1_w) || (c0_w > c1_w);
      if (cmd.dist_load) d_ok <= dfl < $signed({6'b0, p});
      else if (cmd.wall_sel) d_ok <= wcond && (wfl < ps);
      if (cmd.res_load) res_valid <= 1'b1;
      else if (res_ready) res_valid <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.q_load) begin
      qx  <= req.pos_x_q8;
      qy  <= req.pos_y_q8;
      p   <= p_w;
      c0  <= c0_w;
      c1  <= c1_w;
      r1  <= r1_w;
      r   <= r0_w;
      c   <= c0_w;
      fx  <= '0;
      fy  <= '0;
      sat <= 1'b0;
    end
    if (cmd.col_next) c <= c + 1'b1;
    if (cmd.row_next) begin
      r <= r + 1'b1;
      c <= c0;
    end
    if (cmd.geom) begin
      adx <= dxs[IW+9] ? ABW'(-dxs) : ABW'(dxs);
      ady <= dys[IW+9] ? ABW'(-dys) : ABW'(dys);
      sx  <= dxs[IW+9];
      sy  <= dys[IW+9];
    end
    if (cmd.dist_load) d <= dfl[PW-1:0];
    if (cmd.wall_sel) begin
      d    <= wfl[PW-1:0];
      wneg <= wneg_w;
    end
    if (cmd.m1) begin
      num <= NUMW'(cfg.gain_q16) * NUMW'(p - d);
      dd  <= (2*PW)'(d) * (2*PW)'(d);
    end
    if (cmd.m2) d3 <= (3*PW)'(dd) * (3*PW)'(d);
    if (cmd.m3) den <= DENW'(d3) * DENW'(p);
    if (cmd.f_cap) begin
      f <= f_over ? {1'b1, {(FW-1){1'b0}}} : quo[FW-1:0];
      if (f_over) sat <= 1'b1;
    end
    if (cmd.prod_x) prod <= PRODW'(f) * PRODW'(adx);
    if (cmd.prod_y) prod <= PRODW'(f) * PRODW'(ady);
    if (cmd.tx_cap) tx <= quo[PRODW-1:0];
    if (cmd.ty_cap) ty <= quo[PRODW-1:0];
    if (cmd.acc_cell) begin
      fx <= $signed(add_x[SUMW-1:0]);
      fy <= $signed(add_y[SUMW-1:0]);
      if (add_x[SUMW] || add_y[SUMW]) sat <= 1'b1;
    end
    if (cmd.acc_wall) begin
      if (widx == WALL_LEFT || widx == WALL_RIGHT) fx <= $signed(add_w[SUMW-1:0]);
      else fy <= $signed(add_w[SUMW-1:0]);
      if (add_w[SUMW]) sat <= 1'b1;
    end
    if (cmd.wall_init) widx <= WALL_LEFT;
    else if (cmd.wall_next) widx <= widx + 1'b1;
    if (cmd.res_load) begin
      res.force_x   <= fx;
      res.force_y   <= fy;
      res.saturated <= sat;
    end
  end

  always_comb begin
    sts.clr_last  = clr_cnt == AW'(DEPTH - 1);
    sts.win_empty = win_empty;
    sts.occ       = occ;
    sts.sq_done   = sq_done;
    sts.d_ok      = d_ok;
    sts.div_done  = div_done;
    sts.last_col  = c == c1;
    sts.last_row  = r == r1;
    sts.wall_last = widx == WALL_BOT;
    sts.out_busy  = res_valid && !res_ready;
  end

`ifndef ASSERT_OFF
  // a finished result is never overwritten while still waiting
  assert property (@(posedge clk) disable iff (rst)
    cmd.res_load |-> (!res_valid || res_ready))
    else $error("result overwritten while pending");

  // an accepted distance is never zero, so no divide by zero follows
  assert property (@(posedge clk) disable iff (rst)
    (d_ok && (cmd.m1 || cmd.div_comp)) |-> (d != '0))
    else $error("zero distance reached term path");

  // cells are only summed for a non-empty window
  assert property (@(posedge clk) disable iff (rst)
    cmd.acc_cell |-> !win_empty)
    else $error("cell term summed for empty window");
`endif

endmodule

### hw/rtl/pfr_ctrl.sv
// ----------------------------------------------------------------------------
// pfr_ctrl
// Sequencer: grid clear after reset, request intake, window scan per cell,
// the four wall terms and result hand-off.
// ----------------------------------------------------------------------------
module pfr_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          in_type,
  output logic          in_ready,
  output pfr_pkg::cmd_t cmd,
  input  pfr_pkg::sts_t sts
);
  import pfr_pkg::*;

  localparam logic [4:0] S_CLR   = 5'd0;
  localparam logic [4:0] S_IDLE  = 5'd1;
  localparam logic [4:0] S_WIN   = 5'd2;
  localparam logic [4:0] S_RD    = 5'd3;
  localparam logic [4:0] S_CHK   = 5'd4;
  localparam logic [4:0] S_SQS   = 5'd5;
  localparam logic [4:0] S_SQW   = 5'd6;
  localparam logic [4:0] S_DIST  = 5'd7;
  localparam logic [4:0] S_DOK   = 5'd8;
  localparam logic [4:0] S_M1    = 5'd9;
  localparam logic [4:0] S_M2    = 5'd10;
  localparam logic [4:0] S_M3    = 5'd11;
  localparam logic [4:0] S_DTS   = 5'd12;
  localparam logic [4:0] S_DTW   = 5'd13;
  localparam logic [4:0] S_FCAP  = 5'd14;
  localparam logic [4:0] S_PX    = 5'd15;
  localparam logic [4:0] S_DXS   = 5'd16;
  localparam logic [4:0] S_DXW   = 5'd17;
  localparam logic [4:0] S_TXC   = 5'd18;
  localparam logic [4:0] S_PY    = 5'd19;
  localparam logic [4:0] S_DYS   = 5'd20;
  localparam logic [4:0] S_DYW   = 5'd21;
  localparam logic [4:0] S_TYC   = 5'd22;
  localparam logic [4:0] S_ACC   = 5'd23;
  localparam logic [4:0] S_ADV   = 5'd24;
  localparam logic [4:0] S_WSEL  = 5'd25;
  localparam logic [4:0] S_ACCW  = 5'd26;
  localparam logic [4:0] S_WNEXT = 5'd27;
  localparam logic [4:0] S_RES   = 5'd28;

  logic [4:0] state, state_next;
  logic       wall_mode, wall_mode_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      wall_mode <= 1'b0;
    end else begin
      state     <= state_next;
      wall_mode <= wall_mode_next;
    end
  end

  always_comb begin
    cmd            = '0;
    in_ready       = 1'b0;
    state_next     = state;
    wall_mode_next = wall_mode;
    case (state)
      S_CLR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_type == REQ_QUERY) begin
            cmd.q_load     = 1'b1;
            wall_mode_next = 1'b0;
            state_next     = S_WIN;
          end else begin
            cmd.cell_wr = 1'b1;
          end
        end
      end
      S_WIN: begin
        if (sts.win_empty) begin
          cmd.wall_init  = 1'b1;
          wall_mode_next = 1'b1;
          state_next     = S_WSEL;
        end else begin
          state_next = S_RD;
        end
      end
      S_RD:  state_next = S_CHK;
      S_CHK: begin
        cmd.geom   = 1'b1;
        state_next = sts.occ ? S_SQS : S_ADV;
      end
      S_SQS: begin
        cmd.sq_start = 1'b1;
        state_next   = S_SQW;
      end
      S_SQW: if (sts.sq_done) state_next = S_DIST;
      S_DIST: begin
        cmd.dist_load = 1'b1;
        state_next    = S_DOK;
      end
      S_DOK: begin
        if (sts.d_ok) state_next = S_M1;
        else state_next = wall_mode ? S_WNEXT : S_ADV;
      end
      S_M1: begin
        cmd.m1     = 1'b1;
        state_next = S_M2;
      end
      S_M2: begin
        cmd.m2     = 1'b1;
        state_next = S_M3;
      end
      S_M3: begin
        cmd.m3     = 1'b1;
        state_next = S_DTS;
      end
      S_DTS: begin
        cmd.div_term = 1'b1;
        state_next   = S_DTW;
      end
      S_DTW: if (sts.div_done) state_next = S_FCAP;
      S_FCAP: begin
        cmd.f_cap  = 1'b1;
        state_next = wall_mode ? S_ACCW : S_PX;
      end
      S_PX: begin
        cmd.prod_x = 1'b1;
        state_next = S_DXS;
      end
      S_DXS: begin
        cmd.div_comp = 1'b1;
        state_next   = S_DXW;
      end
      S_DXW: if (sts.div_done) state_next = S_TXC;
      S_TXC: begin
        cmd.tx_cap = 1'b1;
        state_next = S_PY;
      end
      S_PY: begin
        cmd.prod_y = 1'b1;
        state_next = S_DYS;
      end
      S_DYS: begin
        cmd.div_comp = 1'b1;
        state_next   = S_DYW;
      end
      S_DYW: if (sts.div_done) state_next = S_TYC;
      S_TYC: begin
        cmd.ty_cap = 1'b1;
        state_next = S_ACC;
      end
      S_ACC: begin
        cmd.acc_cell = 1'b1;
        state_next   = S_ADV;
      end
      S_ADV: begin
        if (sts.last_col) begin
          if (sts.last_row) begin
            cmd.wall_init  = 1'b1;
            wall_mode_next = 1'b1;
            state_next     = S_WSEL;
          end else begin
            cmd.row_next = 1'b1;
            state_next   = S_RD;
          end
        end else begin
          cmd.col_next = 1'b1;
          state_next   = S_RD;
        end
      end
      S_WSEL: begin
        cmd.wall_sel = 1'b1;
        state_next   = S_DOK;
      end
      S_ACCW: begin
        cmd.acc_wall = 1'b1;
        state_next   = S_WNEXT;
      end
      S_WNEXT: begin
        if (sts.wall_last) begin
          state_next = S_RES;
        end else begin
          cmd.wall_next = 1'b1;
          state_next    = S_WSEL;
        end
      end
      S_RES: begin
        if (!sts.out_busy) begin
          cmd.res_load   = 1'b1;
          wall_mode_next = 1'b0;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

### hw/rtl/potential_field_repulsion.sv
// A write request is handled in the idle state itself. A query scans every cell of its
// window; an occupied cell takes an integer square root, and one in range also takes
// three divides on the shared divider; each wall in range takes one more divide.
// One request at a time; a finished result waits in the output register.
// After reset the grid is swept clear, GRID_H*GRID_W cells (8192 by default), during
// which no request is taken; config writes are always taken.
// ----------------------------------------------------------------------------
// potential_field_repulsion
// Occupancy grid with repulsive force query, summed in saturating Q16.16.
// ----------------------------------------------------------------------------
module potential_field_repulsion #(
  parameter int GRID_H     = pfr_pkg::GRID_H_DEF,
  parameter int GRID_W     = pfr_pkg::GRID_W_DEF,
  parameter int MAX_RADIUS = pfr_pkg::MAX_RADIUS_DEF
) (
  input logic      clk,
  input logic      rst,
  pfr_req_if.sink  req,
  pfr_res_if.source res,
  pfr_cfg_if.sink  cfg
);
  import pfr_pkg::*;

  cfg_t cfg_regs;
  req_t req_pl;
  res_t res_pl;
  cmd_t cmd;
  sts_t sts;
  logic in_ready;
  logic res_valid;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.radius_q8   <= PW'(1024);
      cfg_regs.gain_q16    <= GW'(65536);
      cfg_regs.area_height <= AHW'(64);
      cfg_regs.area_width  <= AWW'(128);
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_RADIUS: cfg_regs.radius_q8   <= cfg.data[PW-1:0];
        REG_GAIN:   cfg_regs.gain_q16    <= cfg.data;
        REG_AREA_H: cfg_regs.area_height <= cfg.data[AHW-1:0];
        REG_AREA_W: cfg_regs.area_width  <= cfg.data[AWW-1:0];
        default:    cfg_regs.radius_q8   <= cfg_regs.radius_q8;
      endcase
    end
  end

  always_comb begin
    req_pl.req_type     = req.req_type;
    req_pl.cell_row     = req.cell_row;
    req_pl.cell_col     = req.cell_col;
    req_pl.cell_blocked = req.cell_blocked;
    req_pl.pos_x_q8     = req.pos_x_q8;
    req_pl.pos_y_q8     = req.pos_y_q8;
  end

  assign req.ready     = in_ready;
  assign res.valid     = res_valid;
  assign res.force_x   = res_pl.force_x;
  assign res.force_y   = res_pl.force_y;
  assign res.saturated = res_pl.saturated;

  pfr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_type  (req.req_type),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  pfr_dp #(
    .GRID_H     (GRID_H),
    .GRID_W     (GRID_W),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .cfg       (cfg_regs),
    .req       (req_pl),
    .res_valid (res_valid),
    .res_ready (res.ready),
    .res       (res_pl)
  );

endmodule

### bench/pfr_force_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pfr_force_checker
// Watches the request, result and configuration channels, keeps its own copy
// of the occupancy grid and registers, predicts the force for every query
// and compares each result field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module pfr_force_checker
  import pfr_pkg::*;
(
  input  logic clk,
  input  logic rst,
  pfr_req_if   req,
  pfr_res_if   res,
  pfr_cfg_if   cfg,
  output int   mismatches,
  output int   outstanding
);

  localparam logic [63:0] TERM_CAP = 64'd1 << 40;
  localparam longint SUM_HI = 64'sd2147483647;
  localparam longint SUM_LO = -64'sd2147483648;

  bit             occ [GRID_H_DEF][GRID_W_DEF];
  logic [PW-1:0]  radius;
  logic [GW-1:0]  gain;
  logic [AHW-1:0] area_h;
  logic [AWW-1:0] area_w;
  res_t           force_q [$];

  function automatic logic [63:0] root64(logic [63:0] v);
    logic [63:0] acc, bitv;
    acc  = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= acc + bitv) begin
        v   = v - (acc + bitv);
        acc = (acc >> 1) + bitv;
      end else begin
        acc = acc >> 1;
      end
      bitv = bitv >> 2;
    end
    return acc;
  endfunction

  // eta*(rho-d)*2^24 / (d^3*rho), restoring division with early cap
  function automatic logic [63:0] term_mag(longint p, longint d, inout bit sat);
    logic [63:0] num, den, q, r;
    num = {32'd0, gain} * 64'(p - d);
    den = 64'(d * d * d * p);
    q = num / den;
    r = num % den;
    if (q > TERM_CAP) begin
      sat = 1;
      return TERM_CAP;
    end
    for (int i = 0; i < FRAC; i++) begin
      q = q << 1;
      r = r << 1;
      if (r >= den) begin
        r = r - den;
        q[0] = 1'b1;
      end
      if (q > TERM_CAP) begin
        sat = 1;
        return TERM_CAP;
      end
    end
    return q;
  endfunction

  function automatic void add_sat(inout longint acc, input longint t, inout bit sat);
    acc = acc + t;
    if (acc > SUM_HI) begin
      acc = SUM_HI;
      sat = 1;
    end
    if (acc < SUM_LO) begin
      acc = SUM_LO;
      sat = 1;
    end
  endfunction

  function automatic void wall_term(inout longint acc, input longint d, input longint p,
                                    input bit neg, inout bit sat);
    logic [63:0] f;
    if (d < 1) d = 1;
    if (d >= p) return;
    f = term_mag(p, d, sat);
    add_sat(acc, neg ? -longint'(f) : longint'(f), sat);
  endfunction

  function automatic res_t predict_force(longint x, longint y);
    longint p, fx, fy, r0, r1, c0, c1, dx, dy, d, w, h;
    logic [63:0] adx, ady, f;
    bit sat;
    res_t out;
    fx  = 0;
    fy  = 0;
    sat = 0;
    p = longint'(radius);
    if (p < 1) p = 1;
    if (p > MAX_RADIUS_DEF * 256) p = MAX_RADIUS_DEF * 256;
    c0 = (x - p < 0) ? 0 : (x - p) / 256;
    r0 = (y - p < 0) ? 0 : (y - p) / 256;
    c1 = (x + p) / 256;
    r1 = (y + p) / 256;
    if (c1 > GRID_W_DEF - 1) c1 = GRID_W_DEF - 1;
    if (r1 > GRID_H_DEF - 1) r1 = GRID_H_DEF - 1;
    for (longint r = r0; r <= r1; r++) begin
      for (longint c = c0; c <= c1; c++) begin
        if (!occ[r][c]) continue;
        dx  = x - (c * 256 + 128);
        dy  = y - (r * 256 + 128);
        adx = 64'(dx < 0 ? -dx : dx);
        ady = 64'(dy < 0 ? -dy : dy);
        d = longint'(root64(adx * adx + ady * ady)) - 128;
        if (d < 1) d = 1;
        if (d >= p) continue;
        f = term_mag(p, d, sat);
        add_sat(fx, (dx < 0 ? -1 : 1) * longint'((f * adx) / 64'(d)), sat);
        add_sat(fy, (dy < 0 ? -1 : 1) * longint'((f * ady) / 64'(d)), sat);
      end
    end
    w = longint'(area_w) * 256;
    h = longint'(area_h) * 256;
    // walls: left, right, upper, bottom
    if (x < p) wall_term(fx, x - 205, p, 0, sat);
    if (w - x - 256 < p) wall_term(fx, w - x - 461, p, 1, sat);
    if (y < p) wall_term(fy, y - 205, p, 0, sat);
    if (h - y - 256 < p) wall_term(fy, h - y - 256, p, 1, sat);
    out.force_x   = fx[31:0];
    out.force_y   = fy[31:0];
    out.saturated = sat;
    return out;
  endfunction

  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      foreach (occ[r, c]) occ[r][c] = 0;
      radius = 13'd1024;
      gain   = 32'd65536;
      area_h = 7'd64;
      area_w = 8'd128;
      force_q.delete();
      mismatches = 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_RADIUS: radius = cfg.data[PW-1:0];
          REG_GAIN:   gain   = cfg.data;
          REG_AREA_H: area_h = cfg.data[AHW-1:0];
          REG_AREA_W: area_w = cfg.data[AWW-1:0];
          default: ;
        endcase
      end
      if (res.valid && res.ready) begin
        if (force_q.size() == 0) begin
          $display("%0t unexpected result: force_x %0d force_y %0d saturated %0b",
                   $time, res.force_x, res.force_y, res.saturated);
          mismatches++;
        end else begin
          want = force_q.pop_front();
          if (res.force_x !== want.force_x) begin
            $display("%0t force_x expected %0d got %0d", $time, want.force_x, res.force_x);
            mismatches++;
          end
          if (res.force_y !== want.force_y) begin
            $display("%0t force_y expected %0d got %0d", $time, want.force_y, res.force_y);
            mismatches++;
          end
          if (res.saturated !== want.saturated) begin
            $display("%0t saturated expected %0b got %0b", $time, want.saturated,
                     res.saturated);
            mismatches++;
          end
        end
      end
      if (req.valid && req.ready) begin
        if (req.req_type == REQ_WRITE) begin
          if (req.cell_row < GRID_H_DEF && req.cell_col < GRID_W_DEF)
            occ[req.cell_row][req.cell_col] = req.cell_blocked;
        end else begin
          force_q.push_back(predict_force(longint'(req.pos_x_q8), longint'(req.pos_y_q8)));
        end
      end
    end
    outstanding = force_q.size();
  end

endmodule

### bench/tb_potential_field_repulsion.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_potential_field_repulsion
// Drives cell writes and force queries over several register settings with
// random idling on both sides; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module tb_potential_field_repulsion;
  import pfr_pkg::*;

  localparam int STALL_LIMIT = 1500000;

  logic clk;
  logic rst;
  bit   calm;
  int   mismatches;
  int   outstanding;
  int   stall_cycles;
  logic [ROWW-1:0] last_row;
  logic [COLW-1:0] last_col;

  pfr_req_if req_ch ();
  pfr_res_if res_ch ();
  pfr_cfg_if cfg_ch ();

  potential_field_repulsion dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .res (res_ch),
    .cfg (cfg_ch)
  );

  pfr_force_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .req         (req_ch),
    .res         (res_ch),
    .cfg         (cfg_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    res_ch.ready <= !rst && (calm || $urandom_range(99) >= 29);
  end

  // no progress on any channel for too long ends the run
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic push_req(logic typ, logic [ROWW-1:0] row, logic [COLW-1:0] col,
                          logic blk, logic [XW-1:0] x, logic [YW-1:0] y);
    while (!calm && $urandom_range(99) < 29) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.req_type     <= typ;
    req_ch.cell_row     <= row;
    req_ch.cell_col     <= col;
    req_ch.cell_blocked <= blk;
    req_ch.pos_x_q8     <= x;
    req_ch.pos_y_q8     <= y;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  task automatic write_cell(int row, int col, bit blk);
    push_req(REQ_WRITE, ROWW'(row), COLW'(col), blk, XW'($urandom), YW'($urandom));
  endtask

  task automatic query_at(int x, int y);
    push_req(REQ_QUERY, ROWW'($urandom), COLW'($urandom), 1'($urandom), XW'(x), YW'(y));
  endtask

  // leaves valid high; the caller drops it after the last write
  task automatic write_reg(logic [CFGIW-1:0] idx, logic [GW-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  // drain all pending queries, then let a trailing write finish
  task automatic drain();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic set_regs(int radius, logic [GW-1:0] gain, int ah, int aw);
    drain();
    write_reg(REG_RADIUS, radius);
    write_reg(REG_GAIN, gain);
    write_reg(REG_AREA_H, ah);
    write_reg(REG_AREA_W, aw);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic random_items(int count);
    int pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        last_row = ROWW'($urandom);
        last_col = COLW'($urandom);
        write_cell(int'(last_row), int'(last_col), $urandom_range(99) < 65);
      end else if (pick < 65) begin
        // near the last written cell, down to the floored distance
        query_at(int'(last_col) * 256 + 128 + $urandom_range(0, 1200) - 600 + 600 * 0,
                 int'(last_row) * 256 + $urandom_range(0, 255));
      end else if (pick < 80) begin
        // hug the walls
        query_at($urandom_range(1) ? $urandom_range(0, 1500) : $urandom_range(31000, 32767),
                 $urandom_range(1) ? $urandom_range(0, 1500) : $urandom_range(14800, 16383));
      end else begin
        query_at($urandom_range(0, 32767), $urandom_range(0, 16383));
      end
    end
  endtask

  initial begin
    rst           = 1'b1;
    calm          = 0;
    last_row      = 0;
    last_col      = 0;
    req_ch.valid  = 1'b0;
    req_ch.req_type     = REQ_WRITE;
    req_ch.cell_row     = '0;
    req_ch.cell_col     = '0;
    req_ch.cell_blocked = 1'b0;
    req_ch.pos_x_q8     = '0;
    req_ch.pos_y_q8     = '0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.index  = REG_RADIUS;
    cfg_ch.data   = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part at reset settings
    write_cell(0, 0, 1);
    write_cell(63, 127, 1);
    write_cell(10, 20, 1);
    write_cell(10, 21, 1);
    write_cell(10, 21, 0);
    write_cell(5, 5, 1);
    query_at(0, 0);
    query_at(32767, 16383);
    query_at(20 * 256 + 128, 10 * 256 + 128);
    query_at(128, 128);
    query_at(127 * 256 + 128, 63 * 256 + 128);
    query_at(16384, 8192);
    query_at(205, 205);
    query_at(21 * 256 + 10, 10 * 256 + 250);
    last_row = 10;
    last_col = 20;

    set_regs(0, 32'hFFFF_FFFF, 3, 3);
    query_at(128, 128);
    query_at(20 * 256 + 128, 10 * 256 + 128);
    random_items(15);

    set_regs(2048, 32'hFFFF_FFFF, 127, 255);
    query_at(20 * 256 + 128, 10 * 256 + 128);
    random_items(40);

    set_regs(4096, 32'h0004_0000, 64, 128);
    random_items(20);

    calm = 1;
    set_regs(512, $urandom, 127, 255);
    random_items(60);
    calm = 0;

    set_regs(8191, 0, 0, 0);
    random_items(20);

    set_regs(768, 32'h0010_0000, 40, 100);
    random_items(70);

    set_regs(300, 3000, 10, 20);
    random_items(60);

    drain();
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
